### sv/cst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants for the token scanner.
// ----------------------------------------------------------------------------
package cst_pkg;

    typedef enum logic [4:0] {
        M_IDLE  = 5'd0,
        M_WORD  = 5'd1,
        M_INT   = 5'd2,
        M_DOT   = 5'd3,
        M_FRAC  = 5'd4,
        M_EXPM  = 5'd5,
        M_EXPS  = 5'd6,
        M_EXPD  = 5'd7,
        M_SLASH = 5'd8,
        M_LINEC = 5'd9,
        M_BLOCK = 5'd10,
        M_BSTAR = 5'd11,
        M_LIT   = 5'd12,
        M_LESC  = 5'd13,
        M_EQ    = 5'd14,
        M_PLUS  = 5'd15,
        M_MINUS = 5'd16,
        M_AMP   = 5'd17,
        M_BAR   = 5'd18,
        M_BANG  = 5'd19,
        M_LT    = 5'd20,
        M_GT    = 5'd21
    } scan_mode_t;

    localparam logic [5:0] K_ERROR  = 6'd0;
    localparam logic [5:0] K_END    = 6'd1;
    localparam logic [5:0] K_IDENT  = 6'd13;
    localparam logic [5:0] K_INT    = 6'd14;
    localparam logic [5:0] K_FLOAT  = 6'd15;
    localparam logic [5:0] K_CHAR   = 6'd16;
    localparam logic [5:0] K_STRING = 6'd17;
    localparam logic [5:0] K_ASSIGN = 6'd18;
    localparam logic [5:0] K_PLUS   = 6'd19;
    localparam logic [5:0] K_MINUS  = 6'd20;
    localparam logic [5:0] K_STAR   = 6'd21;
    localparam logic [5:0] K_SLASH  = 6'd22;
    localparam logic [5:0] K_PCT    = 6'd23;
    localparam logic [5:0] K_INC    = 6'd24;
    localparam logic [5:0] K_DEC    = 6'd25;
    localparam logic [5:0] K_AMP    = 6'd26;
    localparam logic [5:0] K_BAR    = 6'd27;
    localparam logic [5:0] K_CARET  = 6'd28;
    localparam logic [5:0] K_TILDE  = 6'd29;
    localparam logic [5:0] K_LAND   = 6'd30;
    localparam logic [5:0] K_LOR    = 6'd31;
    localparam logic [5:0] K_BANG   = 6'd32;
    localparam logic [5:0] K_EQEQ   = 6'd33;
    localparam logic [5:0] K_NE     = 6'd34;
    localparam logic [5:0] K_LT     = 6'd35;
    localparam logic [5:0] K_GT     = 6'd36;
    localparam logic [5:0] K_LE     = 6'd37;
    localparam logic [5:0] K_GE     = 6'd38;
    localparam logic [5:0] K_LPAR   = 6'd39;
    localparam logic [5:0] K_RPAR   = 6'd40;
    localparam logic [5:0] K_LBRACE = 6'd41;
    localparam logic [5:0] K_RBRACE = 6'd42;
    localparam logic [5:0] K_LBRACK = 6'd43;
    localparam logic [5:0] K_RBRACK = 6'd44;
    localparam logic [5:0] K_SEMI   = 6'd45;
    localparam logic [5:0] K_COMMA  = 6'd46;

    localparam logic [1:0] E_NONE    = 2'd0;
    localparam logic [1:0] E_INVALID = 2'd1;
    localparam logic [1:0] E_COMMENT = 2'd2;
    localparam logic [1:0] E_LITERAL = 2'd3;

    localparam int KW_COUNT = 11;
    localparam logic [5:0] KW_BASE = 6'd2;

    // Keyword spellings, right-aligned in 64 bits.
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'h0000_0000_0000_6966,
        64'h0000_0000_656C_7365,
        64'h0000_0077_6869_6C65,
        64'h0000_0000_0066_6F72,
        64'h0000_0000_0000_646F,
        64'h0000_7377_6974_6368,
        64'h0000_0000_6361_7365,
        64'h0064_6566_6175_6C74,
        64'h0000_0062_7265_616B,
        64'h636F_6E74_696E_7565,
        64'h0000_7265_7475_726E
    };

    localparam logic [7:0] CH_NL = 8'h0A;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        unique case (c)
            8'h2A:   k = K_STAR;
            8'h25:   k = K_PCT;
            8'h5E:   k = K_CARET;
            8'h7E:   k = K_TILDE;
            8'h28:   k = K_LPAR;
            8'h29:   k = K_RPAR;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h5B:   k = K_LBRACK;
            8'h5D:   k = K_RBRACK;
            8'h3B:   k = K_SEMI;
            8'h2C:   k = K_COMMA;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

    typedef struct packed {
        logic [5:0] kind;
        logic [1:0] err;
    } tok_code_t;

endpackage

### sv/cst_keyword.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_keyword
// Matches a collected word prefix against the keyword table.
// ----------------------------------------------------------------------------
module cst_keyword
    import cst_pkg::*;
(
    input  logic [63:0] prefix,
    input  logic        too_long,
    output logic [5:0]  kind
);

    always_comb
    begin
        kind = K_IDENT;
        if (!too_long)
        begin
            for (int k = KW_COUNT - 1; k >= 0; k--)
            begin
                if (prefix == KW_TEXT[k])
                begin
                    kind = KW_BASE + 6'(k);
                end
            end
        end
    end

endmodule

### sv/cst_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_core
// Scanner state and the single-step transition that yields up to two tokens.
// ----------------------------------------------------------------------------
module cst_core
    import cst_pkg::*;
#(
    parameter int OFFSET_BITS = 24,
    parameter int LINE_BITS   = 16,
    parameter int SPAN_BITS   = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             char_code,
    input  logic                   end_of_input,
    output logic [1:0]             count,
    output tok_code_t              code0,
    output logic [OFFSET_BITS-1:0] off0,
    output logic [LINE_BITS-1:0]   line0,
    output logic [LINE_BITS-1:0]   col0,
    output logic [SPAN_BITS-1:0]   span0,
    output tok_code_t              code1,
    output logic [OFFSET_BITS-1:0] off1,
    output logic [LINE_BITS-1:0]   line1,
    output logic [LINE_BITS-1:0]   col1,
    output logic [SPAN_BITS-1:0]   span1
);

    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [SPAN_BITS-1:0]   SPAN_MAX = '1;
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [SPAN_BITS-1:0]   SPAN_ONE = SPAN_BITS'(1);

    scan_mode_t             mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] tso_reg, tso_next;
    logic [LINE_BITS-1:0]   tsl_reg, tsl_next;
    logic [LINE_BITS-1:0]   tsc_reg, tsc_next;
    logic [SPAN_BITS-1:0]   span_reg, span_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [LINE_BITS-1:0]   col_reg, col_next;
    logic [63:0]            word_reg, word_next;
    logic                   sq_reg, sq_next;

    logic [5:0] kw_kind;
    logic [SPAN_BITS-1:0] span_inc;
    tok_code_t  flush_code;
    logic       flush_has;
    logic       ext_ok;
    logic       ext_put;
    tok_code_t  ext_code;
    scan_mode_t ext_mode;
    logic [63:0] ext_word;
    logic       ee;
    tok_code_t  st_code;
    logic       st_put;
    scan_mode_t st_mode;

    cst_keyword u_kw
    (
        .prefix   (word_reg),
        .too_long (span_reg > SPAN_BITS'(8)),
        .kind     (kw_kind)
    );

    assign span_inc = (span_reg == SPAN_MAX) ? span_reg : span_reg + SPAN_ONE;
    assign ee = (char_code == 8'h65) || (char_code == 8'h45);

    always_comb
    begin
        flush_has = 1'b1;
        flush_code = '{kind: K_ERROR, err: E_NONE};
        unique case (mode_reg)
            M_WORD:  flush_code.kind = kw_kind;
            M_INT:   flush_code.kind = K_INT;
            M_DOT:   flush_code.err = E_INVALID;
            M_FRAC, M_EXPM, M_EXPS, M_EXPD: flush_code.kind = K_FLOAT;
            M_SLASH: flush_code.kind = K_SLASH;
            M_BLOCK, M_BSTAR: flush_code.err = E_COMMENT;
            M_LIT, M_LESC: flush_code.err = E_LITERAL;
            M_EQ:    flush_code.kind = K_ASSIGN;
            M_PLUS:  flush_code.kind = K_PLUS;
            M_MINUS: flush_code.kind = K_MINUS;
            M_AMP:   flush_code.kind = K_AMP;
            M_BAR:   flush_code.kind = K_BAR;
            M_BANG:  flush_code.kind = K_BANG;
            M_LT:    flush_code.kind = K_LT;
            M_GT:    flush_code.kind = K_GT;
            default: flush_has = 1'b0;
        endcase
    end

    // Extension of the pending token by the current byte.
    always_comb
    begin
        ext_ok   = 1'b0;
        ext_put  = 1'b0;
        ext_code = '{kind: K_ERROR, err: E_NONE};
        ext_mode = mode_reg;
        ext_word = word_reg;
        unique case (mode_reg)
            M_WORD:
            begin
                ext_ok = is_alpha(char_code) || is_digit(char_code);
                if (span_reg < SPAN_BITS'(8))
                begin
                    ext_word = {word_reg[55:0], char_code};
                end
            end
            M_INT:
            begin
                ext_ok = 1'b1;
                if (is_digit(char_code))
                begin
                    ext_mode = M_INT;
                end
                else if (char_code == 8'h2E)
                begin
                    ext_mode = M_FRAC;
                end
                else if (ee)
                begin
                    ext_mode = M_EXPM;
                end
                else
                begin
                    ext_ok = 1'b0;
                end
            end
            M_DOT:
            begin
                ext_ok = is_digit(char_code);
                ext_mode = M_FRAC;
            end
            M_FRAC:
            begin
                ext_ok = is_digit(char_code) || ee;
                ext_mode = ee ? M_EXPM : M_FRAC;
            end
            M_EXPM:
            begin
                ext_ok = is_digit(char_code) || char_code == 8'h2B || char_code == 8'h2D;
                ext_mode = is_digit(char_code) ? M_EXPD : M_EXPS;
            end
            M_EXPS, M_EXPD:
            begin
                ext_ok = is_digit(char_code);
                ext_mode = M_EXPD;
            end
            M_SLASH:
            begin
                ext_ok = char_code == 8'h2F || char_code == 8'h2A;
                ext_mode = (char_code == 8'h2F) ? M_LINEC : M_BLOCK;
            end
            M_LINEC:
            begin
                ext_ok = 1'b1;
                if (char_code == CH_NL)
                begin
                    ext_mode = M_IDLE;
                end
            end
            M_BLOCK:
            begin
                ext_ok = 1'b1;
                if (char_code == 8'h2A)
                begin
                    ext_mode = M_BSTAR;
                end
            end
            M_BSTAR:
            begin
                ext_ok = 1'b1;
                if (char_code == 8'h2F)
                begin
                    ext_mode = M_IDLE;
                end
                else if (char_code != 8'h2A)
                begin
                    ext_mode = M_BLOCK;
                end
            end
            M_LIT:
            begin
                ext_ok = 1'b1;
                if (char_code == 8'h5C)
                begin
                    ext_mode = M_LESC;
                end
                else if (char_code == (sq_reg ? 8'h27 : 8'h22))
                begin
                    ext_put = 1'b1;
                    ext_code.kind = sq_reg ? K_CHAR : K_STRING;
                    ext_mode = M_IDLE;
                end
            end
            M_LESC:
            begin
                ext_ok = 1'b1;
                ext_mode = M_LIT;
            end
            M_EQ, M_BANG, M_LT, M_GT:
            begin
                ext_ok = char_code == 8'h3D;
                ext_put = 1'b1;
                ext_mode = M_IDLE;
                unique case (mode_reg)
                    M_EQ:    ext_code.kind = K_EQEQ;
                    M_BANG:  ext_code.kind = K_NE;
                    M_LT:    ext_code.kind = K_LE;
                    default: ext_code.kind = K_GE;
                endcase
            end
            M_PLUS, M_MINUS, M_AMP, M_BAR:
            begin
                ext_put = 1'b1;
                ext_mode = M_IDLE;
                unique case (mode_reg)
                    M_PLUS:
                    begin
                        ext_ok = char_code == 8'h2B;
                        ext_code.kind = K_INC;
                    end
                    M_MINUS:
                    begin
                        ext_ok = char_code == 8'h2D;
                        ext_code.kind = K_DEC;
                    end
                    M_AMP:
                    begin
                        ext_ok = char_code == 8'h26;
                        ext_code.kind = K_LAND;
                    end
                    default:
                    begin
                        ext_ok = char_code == 8'h7C;
                        ext_code.kind = K_LOR;
                    end
                endcase
            end
            default: ext_ok = 1'b0;
        endcase
    end

    // Start of a new token at the current byte.
    always_comb
    begin
        st_put = 1'b0;
        st_code = '{kind: K_ERROR, err: E_NONE};
        st_mode = M_IDLE;
        if (is_alpha(char_code))
        begin
            st_mode = M_WORD;
        end
        else if (is_digit(char_code))
        begin
            st_mode = M_INT;
        end
        else
        begin
            unique case (char_code)
                8'h2E: st_mode = M_DOT;
                8'h22, 8'h27: st_mode = M_LIT;
                8'h2F: st_mode = M_SLASH;
                8'h3D: st_mode = M_EQ;
                8'h2B: st_mode = M_PLUS;
                8'h2D: st_mode = M_MINUS;
                8'h26: st_mode = M_AMP;
                8'h7C: st_mode = M_BAR;
                8'h21: st_mode = M_BANG;
                8'h3C: st_mode = M_LT;
                8'h3E: st_mode = M_GT;
                default:
                begin
                    st_put = 1'b1;
                    st_code.kind = single_kind(char_code);
                    st_code.err = (single_kind(char_code) == K_ERROR) ? E_INVALID : E_NONE;
                end
            endcase
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        tso_next  = tso_reg;
        tsl_next  = tsl_reg;
        tsc_next  = tsc_reg;
        span_next = span_reg;
        pos_next  = pos_reg;
        line_next = line_reg;
        col_next  = col_reg;
        word_next = word_reg;
        sq_next   = sq_reg;
        count = 2'd0;
        code0 = flush_code;
        off0 = tso_reg;
        line0 = tsl_reg;
        col0 = tsc_reg;
        span0 = span_reg;
        code1 = '{kind: K_END, err: E_NONE};
        off1 = pos_reg;
        line1 = line_reg;
        col1 = col_reg;
        span1 = '0;
        if (end_of_input)
        begin
            mode_next = M_IDLE;
            tso_next = pos_reg;
            tsl_next = line_reg;
            tsc_next = col_reg;
            span_next = '0;
            if (flush_has)
            begin
                count = 2'd2;
            end
            else
            begin
                count = 2'd1;
                code0 = code1;
                off0 = off1;
                line0 = line1;
                col0 = col1;
                span0 = '0;
            end
        end
        else
        begin
            if (mode_reg != M_IDLE && ext_ok)
            begin
                mode_next = ext_mode;
                word_next = ext_word;
                if (mode_reg != M_LINEC)
                begin
                    span_next = span_inc;
                end
                code0 = ext_code;
                span0 = span_inc;
                count = {1'b0, ext_put};
            end
            else
            begin
                mode_next = M_IDLE;
                if (!is_space(char_code))
                begin
                    mode_next = st_mode;
                    tso_next = pos_reg;
                    tsl_next = line_reg;
                    tsc_next = col_reg;
                    span_next = SPAN_ONE;
                    if (is_alpha(char_code))
                    begin
                        word_next = {56'd0, char_code};
                    end
                    if (char_code == 8'h22)
                    begin
                        sq_next = 1'b0;
                    end
                    else if (char_code == 8'h27)
                    begin
                        sq_next = 1'b1;
                    end
                end
                code1 = st_code;
                off1 = pos_reg;
                line1 = line_reg;
                col1 = col_reg;
                span1 = SPAN_ONE;
                if (flush_has && st_put && !is_space(char_code))
                begin
                    count = 2'd2;
                end
                else if (flush_has)
                begin
                    count = 2'd1;
                end
                else if (st_put && !is_space(char_code))
                begin
                    count = 2'd1;
                    code0 = st_code;
                    off0 = pos_reg;
                    line0 = line_reg;
                    col0 = col_reg;
                    span0 = SPAN_ONE;
                end
            end
            pos_next = (pos_reg == OFF_MAX) ? pos_reg : pos_reg + OFFSET_BITS'(1);
            if (char_code == CH_NL)
            begin
                line_next = (line_reg == LINE_MAX) ? line_reg : line_reg + LINE_ONE;
                col_next = LINE_ONE;
            end
            else
            begin
                col_next = (col_reg == LINE_MAX) ? col_reg : col_reg + LINE_ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            tso_reg  <= '0;
            tsl_reg  <= LINE_ONE;
            tsc_reg  <= LINE_ONE;
            span_reg <= '0;
            pos_reg  <= '0;
            line_reg <= LINE_ONE;
            col_reg  <= LINE_ONE;
            word_reg <= '0;
            sq_reg   <= 1'b0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            tso_reg  <= tso_next;
            tsl_reg  <= tsl_next;
            tsc_reg  <= tsc_next;
            span_reg <= span_next;
            pos_reg  <= pos_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            word_reg <= word_next;
            sq_reg   <= sq_next;
        end
    end

endmodule

### sv/c_subset_token_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_subset_token_scanner
// Streaming lexer for a C subset: one source byte in, up to two tokens out.
//
//   Channel | Direction | Payload
//   in      | input     | char_code, end_of_input
//   out     | output    | token fields, error_code, last_of_run
//
// One byte is accepted per cycle when the output side keeps up.
// The scanner state advances when a byte is accepted; the tokens it gives are
// held in a two-entry result buffer and leave one per cycle while out_ready is high.
// A byte that gives two tokens occupies the output until both have left.
// in_ready is high whenever the buffer is empty or drains this cycle.
// Reset puts the scanner between tokens at line 1, column 1.
// ----------------------------------------------------------------------------
module c_subset_token_scanner
    import cst_pkg::*;
#(
    parameter int OFFSET_BITS = 24,
    parameter int LINE_BITS   = 16,
    parameter int SPAN_BITS   = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             char_code,
    input  logic                   end_of_input,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [5:0]             token_kind,
    output logic [OFFSET_BITS-1:0] start_offset,
    output logic [LINE_BITS-1:0]   start_line,
    output logic [LINE_BITS-1:0]   start_column,
    output logic [SPAN_BITS-1:0]   span_length,
    output logic [1:0]             error_code,
    output logic                   last_of_run
);

    localparam int REC_BITS = 8 + OFFSET_BITS + 2 * LINE_BITS + SPAN_BITS;

    logic [1:0] count;
    tok_code_t code0, code1;
    logic [OFFSET_BITS-1:0] off0, off1;
    logic [LINE_BITS-1:0] line0, line1, col0, col1;
    logic [SPAN_BITS-1:0] span0, span1;
    logic step;

    logic [REC_BITS-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [1:0] fill_reg, fill_next;

    assign in_ready = (fill_reg == 2'd0) || (fill_reg == 2'd1 && out_ready);
    assign step = in_valid && in_ready;

    cst_core #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .SPAN_BITS   (SPAN_BITS)
    ) u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .char_code    (char_code),
        .end_of_input (end_of_input),
        .count        (count),
        .code0        (code0),
        .off0         (off0),
        .line0        (line0),
        .col0         (col0),
        .span0        (span0),
        .code1        (code1),
        .off1         (off1),
        .line1        (line1),
        .col1         (col1),
        .span1        (span1)
    );

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (out_valid && out_ready)
        begin
            head_next = tail_reg;
            fill_next = fill_reg - 2'd1;
        end
        if (step && count != 2'd0)
        begin
            head_next = {code0, off0, line0, col0, span0};
            tail_next = {code1, off1, line1, col1, span1};
            fill_next = count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign out_valid = fill_reg != 2'd0;
    assign {token_kind, error_code, start_offset, start_line, start_column, span_length}
        = head_reg;
    assign last_of_run = fill_reg == 2'd1;

endmodule

### sv/cst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks for the token scanner.
// ----------------------------------------------------------------------------
module cst_checker
    import cst_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [5:0] token_kind,
    input logic [1:0] error_code,
    input logic       last_of_run
);

    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != E_NONE |-> token_kind == K_ERROR)
        else $error("error code on a non-error token");

    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid && last_of_run)
        else $error("second token of a pair missing");

    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> !in_ready)
        else $error("input taken while a pair is pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind))
        else $error("stalled transaction changed");

endmodule

bind c_subset_token_scanner cst_checker u_cst_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .token_kind  (token_kind),
    .error_code  (error_code),
    .last_of_run (last_of_run)
);

### sim/tb_c_subset_token_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_c_subset_token_scanner
// Self-checking bench for the streaming C subset token scanner.
//
// A short table of directed source bytes covers keywords, literals, operator
// splitting, invalid bytes and the unterminated comment and literal cases.
// Random C-like token streams with noise bytes and end markers follow. Every
// accepted byte runs through a bench-side lexer that queues the expected
// tokens. Each token on the output is compared field by field with the
// oldest queued one. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_c_subset_token_scanner;
    import cst_pkg::*;

    typedef struct packed {
        logic [5:0]  kind;
        logic [23:0] offs;
        logic [15:0] line;
        logic [15:0] col;
        logic [15:0] span;
        logic [1:0]  err;
        logic        last;
    } token_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
        logic       typed;
        logic [5:0] kind;
        logic [1:0] err;
    } src_byte_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  char_code;
    logic        end_of_input;
    logic        out_valid;
    logic        out_ready;
    logic [5:0]  token_kind;
    logic [23:0] start_offset;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] span_length;
    logic [1:0]  error_code;
    logic        last_of_run;

    src_byte_t   source_q[$];
    token_t      tokens_due[$];
    token_t      step_toks[$];
    int          src_idx;
    int          accepted;
    int          errors;
    string       kw_names[11] = '{"if", "else", "while", "for", "do", "switch",
                                  "case", "default", "break", "continue", "return"};

    scan_mode_t  mode;
    logic [23:0] tok_offs;
    logic [15:0] tok_line;
    logic [15:0] tok_col;
    logic [15:0] tok_span;
    logic [23:0] cur_offs;
    logic [15:0] cur_line;
    logic [15:0] cur_col;
    logic [63:0] word_bits;
    logic        single_quote;

    c_subset_token_scanner u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .char_code(char_code), .end_of_input(end_of_input),
        .out_valid(out_valid), .out_ready(out_ready),
        .token_kind(token_kind), .start_offset(start_offset),
        .start_line(start_line), .start_column(start_column),
        .span_length(span_length), .error_code(error_code),
        .last_of_run(last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic bit letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void emit_tok(logic [5:0] kind, logic [1:0] err);
        token_t t;
        t = '{kind, tok_offs, tok_line, tok_col, tok_span, err, 1'b0};
        step_toks.push_back(t);
    endfunction

    function automatic void open_tok();
        tok_offs = cur_offs;
        tok_line = cur_line;
        tok_col  = cur_col;
        tok_span = '0;
    endfunction

    function automatic void grow_span();
        if (tok_span != '1)
            tok_span++;
    endfunction

    function automatic logic [5:0] word_kind();
        logic [63:0] p;
        if (tok_span > 8)
            return K_IDENT;
        for (int k = 0; k < 11; k++)
        begin
            p = '0;
            for (int i = 0; i < kw_names[k].len(); i++)
                p = (p << 8) | 64'(kw_names[k][i]);
            if (p == word_bits)
                return KW_BASE + 6'(k);
        end
        return K_IDENT;
    endfunction

    function automatic void flush_pending();
        case (mode)
            M_WORD:  emit_tok(word_kind(), E_NONE);
            M_INT:   emit_tok(K_INT, E_NONE);
            M_DOT:   emit_tok(K_ERROR, E_INVALID);
            M_FRAC, M_EXPM, M_EXPS, M_EXPD: emit_tok(K_FLOAT, E_NONE);
            M_SLASH: emit_tok(K_SLASH, E_NONE);
            M_BLOCK, M_BSTAR: emit_tok(K_ERROR, E_COMMENT);
            M_LIT, M_LESC: emit_tok(K_ERROR, E_LITERAL);
            M_EQ:    emit_tok(K_ASSIGN, E_NONE);
            M_PLUS:  emit_tok(K_PLUS, E_NONE);
            M_MINUS: emit_tok(K_MINUS, E_NONE);
            M_AMP:   emit_tok(K_AMP, E_NONE);
            M_BAR:   emit_tok(K_BAR, E_NONE);
            M_BANG:  emit_tok(K_BANG, E_NONE);
            M_LT:    emit_tok(K_LT, E_NONE);
            M_GT:    emit_tok(K_GT, E_NONE);
            default: ;
        endcase
        mode = M_IDLE;
    endfunction

    function automatic bit close_pair(logic [7:0] c, logic [7:0] want, logic [5:0] kind);
        if (c != want)
            return 1'b0;
        grow_span();
        emit_tok(kind, E_NONE);
        mode = M_IDLE;
        return 1'b1;
    endfunction

    function automatic bit extend_tok(logic [7:0] c);
        bit ee;
        ee = (c == "e" || c == "E");
        case (mode)
            M_WORD:
            begin
                if (!letter(c) && !digit(c))
                    return 1'b0;
                if (tok_span < 8)
                    word_bits = (word_bits << 8) | 64'(c);
                grow_span();
                return 1'b1;
            end
            M_INT:
            begin
                if (digit(c))
                begin
                    grow_span();
                    return 1'b1;
                end
                if (c == ".")
                begin
                    grow_span();
                    mode = M_FRAC;
                    return 1'b1;
                end
                if (ee)
                begin
                    grow_span();
                    mode = M_EXPM;
                    return 1'b1;
                end
                return 1'b0;
            end
            M_DOT, M_EXPS, M_EXPD:
            begin
                if (!digit(c))
                    return 1'b0;
                grow_span();
                mode = (mode == M_DOT) ? M_FRAC : M_EXPD;
                return 1'b1;
            end
            M_FRAC:
            begin
                if (digit(c) || ee)
                begin
                    grow_span();
                    if (ee)
                        mode = M_EXPM;
                    return 1'b1;
                end
                return 1'b0;
            end
            M_EXPM:
            begin
                if (c == "+" || c == "-")
                begin
                    grow_span();
                    mode = M_EXPS;
                    return 1'b1;
                end
                if (digit(c))
                begin
                    grow_span();
                    mode = M_EXPD;
                    return 1'b1;
                end
                return 1'b0;
            end
            M_SLASH:
            begin
                if (c != "/" && c != "*")
                    return 1'b0;
                grow_span();
                mode = (c == "/") ? M_LINEC : M_BLOCK;
                return 1'b1;
            end
            M_LINEC:
            begin
                if (c == CH_NL)
                    mode = M_IDLE;
                return 1'b1;
            end
            M_BLOCK:
            begin
                grow_span();
                if (c == "*")
                    mode = M_BSTAR;
                return 1'b1;
            end
            M_BSTAR:
            begin
                grow_span();
                if (c == "/")
                    mode = M_IDLE;
                else if (c != "*")
                    mode = M_BLOCK;
                return 1'b1;
            end
            M_LIT:
            begin
                grow_span();
                if (c == "\\")
                    mode = M_LESC;
                else if (c == (single_quote ? 8'h27 : 8'h22))
                begin
                    emit_tok(single_quote ? K_CHAR : K_STRING, E_NONE);
                    mode = M_IDLE;
                end
                return 1'b1;
            end
            M_LESC:
            begin
                grow_span();
                mode = M_LIT;
                return 1'b1;
            end
            M_EQ:    return close_pair(c, "=", K_EQEQ);
            M_PLUS:  return close_pair(c, "+", K_INC);
            M_MINUS: return close_pair(c, "-", K_DEC);
            M_AMP:   return close_pair(c, "&", K_LAND);
            M_BAR:   return close_pair(c, "|", K_LOR);
            M_BANG:  return close_pair(c, "=", K_NE);
            M_LT:    return close_pair(c, "=", K_LE);
            M_GT:    return close_pair(c, "=", K_GE);
            default: return 1'b0;
        endcase
    endfunction

    function automatic void start_tok(logic [7:0] c);
        logic [5:0] k;
        if (c == " " || (c >= 8'd9 && c <= 8'd13))
            return;
        open_tok();
        grow_span();
        if (letter(c))
        begin
            word_bits = 64'(c);
            mode = M_WORD;
            return;
        end
        if (digit(c))
        begin
            mode = M_INT;
            return;
        end
        case (c)
            ".":   mode = M_DOT;
            8'h22: begin single_quote = 1'b0; mode = M_LIT; end
            8'h27: begin single_quote = 1'b1; mode = M_LIT; end
            "/":   mode = M_SLASH;
            "=":   mode = M_EQ;
            "+":   mode = M_PLUS;
            "-":   mode = M_MINUS;
            "&":   mode = M_AMP;
            "|":   mode = M_BAR;
            "!":   mode = M_BANG;
            "<":   mode = M_LT;
            ">":   mode = M_GT;
            default:
            begin
                case (c)
                    "*": k = K_STAR;   "%": k = K_PCT;    "^": k = K_CARET;
                    "~": k = K_TILDE;  "(": k = K_LPAR;   ")": k = K_RPAR;
                    "{": k = K_LBRACE; "}": k = K_RBRACE; "[": k = K_LBRACK;
                    "]": k = K_RBRACK; ";": k = K_SEMI;   ",": k = K_COMMA;
                    default: k = K_ERROR;
                endcase
                emit_tok(k, (k == K_ERROR) ? E_INVALID : E_NONE);
            end
        endcase
    endfunction

    function automatic void scan_byte(logic [7:0] c, logic eoi);
        step_toks.delete();
        if (eoi)
        begin
            flush_pending();
            open_tok();
            emit_tok(K_END, E_NONE);
        end
        else
        begin
            if (mode == M_IDLE || !extend_tok(c))
            begin
                flush_pending();
                start_tok(c);
            end
            if (cur_offs != '1)
                cur_offs++;
            if (c == CH_NL)
            begin
                if (cur_line != '1)
                    cur_line++;
                cur_col = 16'd1;
            end
            else if (cur_col != '1)
                cur_col++;
        end
        if (step_toks.size() > 0)
            step_toks[step_toks.size()-1].last = 1'b1;
        foreach (step_toks[i])
            tokens_due.push_back(step_toks[i]);
    endfunction

    function automatic void add_byte(logic [7:0] c, logic eoi = 1'b0,
                                     logic typed = 1'b0, logic [5:0] kind = K_ERROR,
                                     logic [1:0] err = E_NONE);
        src_byte_t s;
        s = '{c, eoi, typed, kind, err};
        source_q.push_back(s);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len()-1)];
    endfunction

    function automatic void add_random_token();
        string alpha = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        string digs = "0123456789";
        string ops = "=+-*/%&|^~!<>(){}[];,";
        string lit = "abc xyz09\\\"'\n\t*/";
        string ws = " \t\n\r\v\f";
        int n;
        logic [7:0] q;
        case ($urandom_range(0, 19))
            0, 1:
                add_text(kw_names[$urandom_range(0, 10)]);
            2, 3, 4:
            begin
                add_byte(pick(alpha));
                n = $urandom_range(0, 11);
                repeat (n) add_byte(($urandom_range(0, 3) == 0) ? pick(digs) : pick(alpha));
            end
            5, 6:
            begin
                if ($urandom_range(0, 4) == 0)
                    add_byte(".");
                else
                    repeat ($urandom_range(1, 4)) add_byte(pick(digs));
                if ($urandom_range(0, 1)) add_byte(".");
                repeat ($urandom_range(0, 3)) add_byte(pick(digs));
                if ($urandom_range(0, 1))
                begin
                    add_byte($urandom_range(0, 1) ? "e" : "E");
                    if ($urandom_range(0, 1)) add_byte($urandom_range(0, 1) ? "+" : "-");
                    repeat ($urandom_range(0, 3)) add_byte(pick(digs));
                end
            end
            7, 8:
            begin
                q = $urandom_range(0, 1) ? 8'h22 : 8'h27;
                add_byte(q);
                repeat ($urandom_range(0, 6)) add_byte(pick(lit));
                if ($urandom_range(0, 7) != 0) add_byte(q);
            end
            9:
            begin
                add_text("//");
                repeat ($urandom_range(0, 6)) add_byte(pick(lit));
                add_byte(CH_NL);
            end
            10:
            begin
                add_text("/*");
                repeat ($urandom_range(0, 6)) add_byte(pick(lit));
                repeat ($urandom_range(1, 2)) add_byte("*");
                if ($urandom_range(0, 7) != 0) add_byte("/");
            end
            11, 12, 13, 14:
                repeat ($urandom_range(1, 2)) add_byte(pick(ops));
            15, 16, 17:
                repeat ($urandom_range(1, 2)) add_byte(pick(ws));
            18:
                add_byte(8'($urandom_range(0, 255)));
            default:
                if ($urandom_range(0, 2) == 0)
                    add_byte(8'($urandom_range(0, 255)), 1'b1);
                else
                    add_byte(pick(ops));
        endcase
    endfunction

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        char_code = '0;
        end_of_input = 1'b0;
        out_ready = 1'b0;
        errors = 0;
        accepted = 0;
        src_idx = 0;
        mode = M_IDLE;
        tok_offs = '0;
        tok_line = 16'd1;
        tok_col = 16'd1;
        tok_span = '0;
        cur_offs = '0;
        cur_line = 16'd1;
        cur_col = 16'd1;
        word_bits = '0;
        single_quote = 1'b0;

        add_byte(8'h00, 1'b1, 1'b1, K_END, E_NONE);
        add_text("if ");
        add_byte(8'h80, 1'b0, 1'b1, K_ERROR, E_INVALID);
        add_byte(8'hFF, 1'b0, 1'b1, K_ERROR, E_INVALID);
        add_byte(8'h00, 1'b0, 1'b1, K_ERROR, E_INVALID);
        add_text("<<.;1e+;");
        add_text("/*x");
        add_byte(8'hFF, 1'b1, 1'b1, K_ERROR, E_COMMENT);
        add_text("\"a");
        add_byte(8'h7F, 1'b1, 1'b1, K_ERROR, E_LITERAL);
        while (source_q.size() < 1270)
            add_random_token();
        add_byte(8'h00, 1'b1);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        src_byte_t s;
        logic      quiet;
        logic      drive;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                s = source_q[src_idx];
                scan_byte(s.ch, s.eoi);
                if (s.typed && (step_toks.size() == 0 || step_toks[0].kind != s.kind
                                || step_toks[0].err != s.err))
                    report_mismatch("directed kind",
                                    step_toks.size() ? 32'(step_toks[0].kind) : 32'd0,
                                    32'(s.kind));
                src_idx++;
                accepted++;
            end
            quiet = (accepted >= 500 && accepted < 700);
            drive = in_valid && !(in_valid && in_ready);
            if (!drive && src_idx < source_q.size())
                drive = quiet || $urandom_range(0, 99) >= 37;
            in_valid <= drive;
            if (drive && src_idx < source_q.size())
            begin
                char_code    <= source_q[src_idx].ch;
                end_of_input <= source_q[src_idx].eoi;
            end
            out_ready <= quiet || $urandom_range(0, 99) >= 37;
        end
    end

    always @(posedge clk)
    begin
        token_t t;
        if (rst_n && out_valid && out_ready)
        begin
            if (tokens_due.size() == 0)
                report_mismatch("unexpected token kind", 32'(token_kind), 32'd0);
            else
            begin
                t = tokens_due.pop_front();
                if (token_kind != t.kind)
                    report_mismatch("token_kind", 32'(token_kind), 32'(t.kind));
                if (start_offset != t.offs)
                    report_mismatch("start_offset", 32'(start_offset), 32'(t.offs));
                if (start_line != t.line)
                    report_mismatch("start_line", 32'(start_line), 32'(t.line));
                if (start_column != t.col)
                    report_mismatch("start_column", 32'(start_column), 32'(t.col));
                if (span_length != t.span)
                    report_mismatch("span_length", 32'(span_length), 32'(t.span));
                if (error_code != t.err)
                    report_mismatch("error_code", 32'(error_code), 32'(t.err));
                if (last_of_run != t.last)
                    report_mismatch("last_of_run", 32'(last_of_run), 32'(t.last));
            end
        end
    end

    initial
    begin
        wait (rst_n);
        wait (src_idx == source_q.size() && tokens_due.size() == 0);
        repeat (20) @(posedge clk);
        if (tokens_due.size() != 0)
            report_mismatch("tokens left over", 32'(tokens_due.size()), 32'd0);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("status: fail");
        $finish;
    end

endmodule
